### hw/rtl/rqb_pkg.sv
// package for the retransmit queue: widths, codes, reset values, cell types
// no dependencies
`timescale 1ns / 1ps
package rqb_pkg;
    localparam int QueueDepthDefault = 8;
    localparam int SeqW = 32;
    localparam int LenW = 16;
    localparam int RtoW = 32;
    localparam int RetryW = 4;
    localparam int TimeW = 32;
    localparam int RtoInitW = 16;
    localparam int RtoMaxW = 20;
    localparam int CfgW = 20;
    localparam int CfgIdxW = 2;
    localparam logic [RtoInitW-1:0] RtoInitReset = 16'd1000;
    localparam logic [RtoMaxW-1:0] RtoMaxReset = 20'd60000;
    localparam logic [RetryW-1:0] MaxRetriesReset = 4'd8;

    localparam logic [CfgIdxW-1:0] CFG_RTO_INITIAL = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_RTO_MAX = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_MAX_RETRIES = 2'd2;

    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_ACK = 2'd1,
        KIND_TICK = 2'd2,
        KIND_OPEN = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ACT_DONE = 2'd0,
        ACT_RESEND = 2'd1,
        ACT_GIVEUP = 2'd2,
        ACT_DROP = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [SeqW-1:0] seq;
        logic [LenW-1:0] len;
        logic [RtoW-1:0] rto;
        logic [RetryW-1:0] retries;
        logic [TimeW-1:0] deadline;
    } entry_t;

    // per-cycle command into the cell row
    typedef struct packed {
        logic shift;   // rotate by one cell toward the head
        logic keep;    // head entry survives the rotation
        logic update;  // backoff update flag; the cell row does not read it
        logic load;    // write the add entry at the tail
    } cell_ctl_t;
endpackage

### hw/rtl/retransmit_queue_backoff_top.sv
// retransmit queue with exponential backoff, top level
// depends on rqb_pkg, rqb_chain, rqb_cell
//
// Holds up to QUEUE_DEPTH segment descriptors in a row of cells that rotate
// one position per cycle toward cell 0, where the single compare and backoff
// unit looks at the head. Add and open go from the walk state to the output
// state. Ack and tick walk the queue one entry per cycle, then give the final word;
// a resend word still stalled when the next expired entry reaches the head
// holds the walk. The walk over the cells sets the rate. One item at a
// time; a finished result sits in the output register while stall is high.
`timescale 1ns / 1ps
module retransmit_queue_backoff_top
    import rqb_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDefault
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgW-1:0]     cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          kind,
    input  logic [SeqW-1:0]     segment_seq,
    input  logic [LenW-1:0]     segment_len,
    input  logic [SeqW-1:0]     ack_number,
    input  logic [TimeW-1:0]    now_ms,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          action,
    output logic [SeqW-1:0]     seg_seq,
    output logic [LenW-1:0]     seg_len,
    output logic [2:0]          slot,
    output logic [3:0]          queue_count,
    output logic                last
);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    logic [RtoInitW-1:0] rto_init_reg;
    logic [RtoMaxW-1:0]  rto_max_reg;
    logic [RetryW-1:0]   max_retries_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rto_init_reg <= RtoInitReset;
            rto_max_reg <= RtoMaxReset;
            max_retries_reg <= MaxRetriesReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RTO_INITIAL: rto_init_reg <= cfg_data[RtoInitW-1:0];
                CFG_RTO_MAX:     rto_max_reg <= cfg_data;
                CFG_MAX_RETRIES: max_retries_reg <= cfg_data[RetryW-1:0];
                default: ;
            endcase
        end
    end

    state_t state_reg, state_next;
    kind_t kind_reg, kind_next;
    logic [SeqW-1:0] ack_reg, ack_next;
    logic [TimeW-1:0] now_reg, now_next;
    logic [SeqW-1:0] aseq_reg, aseq_next;
    logic [LenW-1:0] alen_reg, alen_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [CntW-1:0] idx_reg, idx_next;      // entries visited in the walk
    logic [CntW-1:0] wr_reg, wr_next;        // survivors kept so far
    logic alive_reg, alive_next;
    logic stop_reg, stop_next;               // gave up: rotate the rest untouched
    logic ov_reg, ov_next;
    logic [1:0] act_reg, act_next;
    logic [SeqW-1:0] oseq_reg, oseq_next;
    logic [LenW-1:0] olen_reg, olen_next;
    logic [2:0] oslot_reg, oslot_next;
    logic [3:0] ocnt_reg, ocnt_next;
    logic olast_reg, olast_next;

    cell_ctl_t ctl;
    entry_t head, head_new, add_entry;
    logic [SeqW-1:0] end_seq;
    logic expired, can_retry;
    logic [RtoW:0] dbl;
    logic [RtoW-1:0] rto_new;
    logic in_acc, out_free;

    assign in_acc = in_valid && !in_stall;
    assign out_free = !ov_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || ov_reg;

    assign end_seq = head.seq + SeqW'(head.len);
    assign expired = now_reg >= head.deadline;
    assign can_retry = head.retries < max_retries_reg;
    assign dbl = {head.rto, 1'b0};
    assign rto_new = (dbl > (RtoW + 1)'(rto_max_reg)) ? RtoW'(rto_max_reg) : dbl[RtoW-1:0];

    always_comb
    begin
        head_new = head;
        if (kind_reg == KIND_TICK && !stop_reg && alive_reg && expired && can_retry)
        begin
            head_new.rto = rto_new;
            head_new.retries = head.retries + RetryW'(1);
            head_new.deadline = now_reg + rto_new;
        end
        add_entry.seq = aseq_reg;
        add_entry.len = alen_reg;
        add_entry.rto = RtoW'(rto_init_reg);
        add_entry.retries = '0;
        add_entry.deadline = now_reg + TimeW'(rto_init_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_acc)
                    state_next = ST_WALK;
            ST_WALK:
                if (kind_reg == KIND_ADD || kind_reg == KIND_OPEN || idx_reg == count_reg)
                    state_next = ST_OUT;
            ST_OUT:
                if (out_free)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        kind_next = kind_reg;
        ack_next = ack_reg;
        now_next = now_reg;
        aseq_next = aseq_reg;
        alen_next = alen_reg;
        count_next = count_reg;
        idx_next = idx_reg;
        wr_next = wr_reg;
        alive_next = alive_reg;
        stop_next = stop_reg;
        ov_next = ov_reg && out_stall;
        act_next = act_reg;
        oseq_next = oseq_reg;
        olen_next = olen_reg;
        oslot_next = oslot_reg;
        ocnt_next = ocnt_reg;
        olast_next = olast_reg;
        ctl = '0;
        unique case (state_reg)
            ST_IDLE:
                if (in_acc)
                begin
                    kind_next = kind_t'(kind);
                    ack_next = ack_number;
                    now_next = now_ms;
                    aseq_next = segment_seq;
                    alen_next = segment_len;
                    idx_next = '0;
                    wr_next = '0;
                    stop_next = 1'b0;
                end
            ST_WALK:
                if (kind_reg == KIND_ADD)
                begin
                    if (count_reg == CntW'(QUEUE_DEPTH))
                        act_next = ACT_DROP;
                    else
                    begin
                        act_next = ACT_DONE;
                        ctl.load = 1'b1;
                        count_next = count_reg + CntW'(1);
                    end
                    oseq_next = aseq_reg;
                    olen_next = alen_reg;
                    oslot_next = (count_reg == CntW'(QUEUE_DEPTH)) ? 3'd0 : 3'(count_reg);
                end
                else if (kind_reg == KIND_OPEN)
                begin
                    count_next = '0;
                    alive_next = 1'b1;
                    act_next = ACT_DONE;
                    oseq_next = '0;
                    olen_next = '0;
                    oslot_next = '0;
                end
                else if (idx_reg != count_reg)
                begin
                    // the head rotates to the tail on every step of the walk; an output word
                    // must have drained before a resend or give-up word is produced
                    if (kind_reg == KIND_TICK && !stop_reg && alive_reg && expired
                        && ov_reg && out_stall)
                    begin
                        ctl = '0;
                    end
                    else
                    begin
                        ctl.shift = 1'b1;
                        ctl.keep = 1'b1;
                        idx_next = idx_reg + CntW'(1);
                        wr_next = count_reg - CntW'(1);
                        if (kind_reg == KIND_ACK)
                        begin
                            ctl.keep = !(ack_reg > end_seq);
                            wr_next = wr_reg + CntW'(ctl.keep);
                        end
                        if (kind_reg == KIND_TICK && !stop_reg && alive_reg && expired)
                        begin
                            ov_next = 1'b1;
                            oseq_next = head.seq;
                            olen_next = head.len;
                            oslot_next = 3'(idx_reg);
                            ocnt_next = 4'(count_reg);
                            if (can_retry)
                            begin
                                act_next = ACT_RESEND;
                                olast_next = 1'b0;
                            end
                            else
                            begin
                                act_next = ACT_GIVEUP;
                                olast_next = 1'b1;
                                alive_next = 1'b0;
                                stop_next = 1'b1;
                            end
                        end
                    end
                end
                else if (kind_reg == KIND_ACK)
                    count_next = wr_reg;
            ST_OUT:
                if (out_free)
                begin
                    if (!stop_reg)
                    begin
                        ov_next = 1'b1;
                        if (kind_reg == KIND_TICK)
                        begin
                            act_next = ACT_DONE;
                            oseq_next = '0;
                            olen_next = '0;
                            oslot_next = '0;
                        end
                        ocnt_next = 4'(count_reg);
                        olast_next = 1'b1;
                    end
                end
            default: ;
        endcase
        if (kind_reg == KIND_ACK && state_reg == ST_WALK && idx_reg == count_reg)
        begin
            act_next = ACT_DONE;
            oseq_next = '0;
            olen_next = '0;
            oslot_next = '0;
        end
    end

    // unvisited entries and kept survivors both move down one cell per step, so a
    // survivor lands just above those kept so far: count-1-idx+wr; a tick keeps all
    logic [CntW-1:0] wpos;
    assign wpos = (kind_reg == KIND_ACK) ? count_reg - idx_reg + wr_reg - CntW'(1)
                                         : count_reg - CntW'(1);

    rqb_chain #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_chain (
        .clk       (clk),
        .ctl       (ctl),
        .count     (count_reg),
        .wr_pos    (wpos),
        .head_new  (head_new),
        .add_entry (add_entry),
        .head      (head)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            idx_reg <= '0;
            wr_reg <= '0;
            alive_reg <= 1'b0;
            stop_reg <= 1'b0;
            ov_reg <= 1'b0;
            kind_reg <= KIND_ADD;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg <= idx_next;
            wr_reg <= wr_next;
            alive_reg <= alive_next;
            stop_reg <= stop_next;
            ov_reg <= ov_next;
            kind_reg <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ack_reg <= ack_next;
        now_reg <= now_next;
        aseq_reg <= aseq_next;
        alen_reg <= alen_next;
        act_reg <= act_next;
        oseq_reg <= oseq_next;
        olen_reg <= olen_next;
        oslot_reg <= oslot_next;
        ocnt_reg <= ocnt_next;
        olast_reg <= olast_next;
    end

    assign out_valid = ov_reg;
    assign action = act_reg;
    assign seg_seq = oseq_reg;
    assign seg_len = olen_reg;
    assign slot = oslot_reg;
    assign queue_count = ocnt_reg;
    assign last = olast_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(QUEUE_DEPTH))
        else $error("queue count above depth");
    a_idle_no_walk: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !ctl.shift && !ctl.load)
        else $error("cells moved while idle");
    a_giveup_closes: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && act_reg == ACT_GIVEUP |-> !alive_reg)
        else $error("give-up left connection alive");
    a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> in_stall)
        else $error("input open during a walk");
`endif
endmodule

### hw/rtl/rqb_cell.sv
// one queue cell: holds an entry, takes load_entry on a load and otherwise its neighbor's entry on a shift
// depends on rqb_pkg
`timescale 1ns / 1ps
module rqb_cell
    import rqb_pkg::*;
(
    input  logic   clk,
    input  logic   shift,
    input  logic   load,
    input  entry_t from_next,
    input  entry_t load_entry,
    output entry_t held
);
    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (load)
            entry_next = load_entry;
        else if (shift)
            entry_next = from_next;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign held = entry_reg;
endmodule

### hw/rtl/rqb_chain.sv
// row of queue cells rotating toward cell 0; a kept head's entry returns at the tail
// depends on rqb_pkg, rqb_cell
`timescale 1ns / 1ps
module rqb_chain
    import rqb_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDefault,
    parameter int CntW = $clog2(QUEUE_DEPTH + 1)
)
(
    input  logic            clk,
    input  cell_ctl_t       ctl,
    input  logic [CntW-1:0] count,      // live entries
    input  logic [CntW-1:0] wr_pos,     // tail position for survivors
    input  entry_t          head_new,   // updated head entry
    input  entry_t          add_entry,
    output entry_t          head
);
    entry_t held [QUEUE_DEPTH];
    entry_t nbr [QUEUE_DEPTH];
    logic   ld [QUEUE_DEPTH];

    // a shift rotates the live entries; a kept head goes back to position wr_pos,
    // which is count-1 unless survivors compact in front of it
    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            always_comb
            begin
                if (g == QUEUE_DEPTH - 1)
                    nbr[g] = held[g];
                else
                    nbr[g] = held[g + 1];
                ld[g] = 1'b0;
                if (ctl.load && count == CntW'(g))
                    ld[g] = 1'b1;
            end
            rqb_cell u_cell (
                .clk        (clk),
                .shift      (ctl.shift),
                .load       (ld[g] || (ctl.shift && ctl.keep && wr_pos == CntW'(g))),
                .from_next  (nbr[g]),
                .load_entry (ctl.load ? add_entry : head_new),
                .held       (held[g])
            );
        end
    endgenerate

    assign head = held[0];
endmodule
